FILE: hw/rtl/okvm_pkg.sv
// Shared constants and types for the ordered key/value map.
package okvm_pkg;
  localparam int CAPACITY   = 256;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = $clog2(CAPACITY);
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    OP_GET    = 3'd0,
    OP_FLOOR  = 3'd1,
    OP_MIN    = 3'd2,
    OP_INSERT = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_INVALID   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;
endpackage

FILE: hw/rtl/okvm_ram.sv
// Generic simple dual-port RAM with registered read.
module okvm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/ordered_key_value_map.sv
// Ordered key/value map top level: unordered slot store with scanning search.
// Entries sit unsorted in slots 0 to count-1 of a key RAM and a value RAM.
// Every operation but an invalid one scans all held keys, one RAM read per
// cycle; item_stall stays high until the result of that scan has entered
// the output register, so a new word is taken only after that. Remove
// moves the last entry into the freed slot. A finished result waits in the
// output register while the next word is already taken.
// No clearing pass runs after reset.
module ordered_key_value_map import okvm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic [2:0]            op,
  input  logic [KEY_BITS-1:0]   key,
  input  logic [VALUE_BITS-1:0] value,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [1:0]            status,
  output logic [KEY_BITS-1:0]   key_out,
  output logic [VALUE_BITS-1:0] value_out,
  output logic [COUNT_BITS-1:0] entry_count_out
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_VWAIT, S_REM2, S_RESP} state_t;

  state_t                state;
  logic                  compare_signed;
  logic [2:0]            op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] ra;
  logic                  rd_v;
  logic [ADDR_BITS-1:0]  rd_idx;
  logic                  have;
  logic [ADDR_BITS-1:0]  bidx;
  logic [KEY_BITS-1:0]   bkey;
  logic [KEY_BITS-1:0]   last_key;
  logic [1:0]            r_status;
  logic [KEY_BITS-1:0]   r_key;
  logic [VALUE_BITS-1:0] r_value;

  logic [ADDR_BITS-1:0]  k_raddr, v_raddr, k_waddr, v_waddr;
  logic [KEY_BITS-1:0]   k_rdata, k_wdata;
  logic [VALUE_BITS-1:0] v_rdata, v_wdata;
  logic                  k_we, v_we;
  logic [ADDR_BITS-1:0]  last_idx;
  logic [KEY_BITS-1:0]   sign_flip;
  logic [KEY_BITS-1:0]   rank_d, rank_b, rank_k;
  logic                  better;

  okvm_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  okvm_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_value_ram (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );

  assign item_stall = (state != S_IDLE);
  assign last_idx   = ADDR_BITS'(count - COUNT_BITS'(1));
  assign sign_flip  = {compare_signed, {(KEY_BITS-1){1'b0}}};
  assign rank_d     = k_rdata ^ sign_flip;
  assign rank_b     = bkey ^ sign_flip;
  assign rank_k     = key_q ^ sign_flip;

  always_comb begin
    unique case (op_q)
      OP_MIN:   better = !have || (rank_d < rank_b);
      OP_FLOOR: better = (rank_d <= rank_k) && (!have || (rank_d > rank_b));
      default:  better = (k_rdata == key_q);
    endcase
  end

  always_comb begin
    k_raddr = ra[ADDR_BITS-1:0];
    v_raddr = bidx;
    k_we    = 1'b0;
    v_we    = 1'b0;
    k_waddr = bidx;
    v_waddr = bidx;
    k_wdata = last_key;
    v_wdata = v_rdata;
    if (state == S_FIN) begin
      k_raddr = last_idx;
      if (op_q == OP_INSERT && !have && count != COUNT_BITS'(CAPACITY)) begin
        k_we    = 1'b1;
        v_we    = 1'b1;
        k_waddr = count[ADDR_BITS-1:0];
        v_waddr = count[ADDR_BITS-1:0];
        k_wdata = key_q;
        v_wdata = value_q;
      end
    end else if (state == S_VWAIT) begin
      if (op_q == OP_INSERT) begin
        v_we    = 1'b1;
        v_wdata = value_q;
      end
      v_raddr = last_idx;
    end else if (state == S_REM2) begin
      k_we = 1'b1;
      v_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      compare_signed <= 1'b0;
      count          <= '0;
      result_valid   <= 1'b0;
      rd_v           <= 1'b0;
    end else begin
      if (cfg_we) begin
        compare_signed <= cfg_wdata;
      end
      if (result_valid && !result_stall && state != S_RESP) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op_q    <= op;
            key_q   <= key;
            value_q <= value;
            ra      <= '0;
            rd_v    <= 1'b0;
            have    <= 1'b0;
            r_key   <= '0;
            r_value <= '0;
            if (op == OP_MIN || (op <= OP_REMOVE && key != '0)) begin
              state <= S_SCAN;
            end else begin
              r_status <= ST_INVALID;
              state    <= S_RESP;
            end
          end
        end
        S_SCAN: begin
          if (ra < count) begin
            rd_idx <= ra[ADDR_BITS-1:0];
            ra     <= ra + COUNT_BITS'(1);
            rd_v   <= 1'b1;
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              state <= S_FIN;
            end
          end
          if (rd_v && better) begin
            have <= 1'b1;
            bidx <= rd_idx;
            bkey <= k_rdata;
          end
        end
        S_FIN: begin
          if (have) begin
            state <= S_VWAIT;
          end else if (op_q == OP_INSERT) begin
            if (count == COUNT_BITS'(CAPACITY)) begin
              r_status <= ST_FULL;
            end else begin
              r_status <= ST_OK;
              count    <= count + COUNT_BITS'(1);
            end
            state <= S_RESP;
          end else begin
            r_status <= ST_NOT_FOUND;
            state    <= S_RESP;
          end
        end
        S_VWAIT: begin
          r_status <= ST_OK;
          r_value  <= v_rdata;
          if (op_q == OP_FLOOR || op_q == OP_MIN) begin
            r_key <= bkey;
          end
          if (op_q == OP_REMOVE) begin
            last_key <= k_rdata;
            state    <= S_REM2;
          end else begin
            state <= S_RESP;
          end
        end
        S_REM2: begin
          count <= count - COUNT_BITS'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (!result_valid || !result_stall) begin
            result_valid    <= 1'b1;
            status          <= r_status;
            key_out         <= r_key;
            value_out       <= r_value;
            entry_count_out <= count;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  a_count_change: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) && !$past(rst) |-> state == S_RESP)
    else $error("entry count changed outside commit");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> ra <= count)
    else $error("scan pointer past held entries");
endmodule

FILE: dv/ordered_key_value_map_tb.sv
// Testbench for the ordered key/value map: directed and random words checked against a predictor.
`timescale 1ns / 1ps
module ordered_key_value_map_tb;
  import okvm_pkg::*;

  typedef struct packed {
    logic [1:0]            status;
    logic [KEY_BITS-1:0]   key_out;
    logic [VALUE_BITS-1:0] value_out;
    logic [COUNT_BITS-1:0] count;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [2:0] op = 3'd0;
  logic [KEY_BITS-1:0] key = '0;
  logic [VALUE_BITS-1:0] value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] status;
  logic [KEY_BITS-1:0] key_out;
  logic [VALUE_BITS-1:0] value_out;
  logic [COUNT_BITS-1:0] entry_count_out;

  ordered_key_value_map dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .key(key), .value(value),
    .result_valid(result_valid), .result_stall(result_stall),
    .status(status), .key_out(key_out), .value_out(value_out),
    .entry_count_out(entry_count_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [KEY_BITS-1:0]   map_keys[CAPACITY];
  logic [VALUE_BITS-1:0] map_vals[CAPACITY];
  int unsigned map_count;
  logic signed_order;
  answer_t pending_answers[$];
  int unsigned errors;
  int unsigned answers_seen;
  int unsigned words_sent;
  longint unsigned cycles;
  bit hold_off;
  bit quiet_out;
  bit quiet_in;
  logic [KEY_BITS-1:0] used_keys[$];

  function automatic logic [KEY_BITS-1:0] rank(logic [KEY_BITS-1:0] k);
    return signed_order ? (k ^ (1 << (KEY_BITS - 1))) : k;
  endfunction

  function automatic int find_key(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < map_count; i++)
      if (map_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic answer_t predict_answer(logic [2:0] o, logic [KEY_BITS-1:0] k,
                                             logic [VALUE_BITS-1:0] v);
    answer_t a;
    int at;
    a = '0;
    a.status = ST_INVALID;
    at = -1;
    if (o == OP_MIN) begin
      for (int i = 0; i < map_count; i++)
        if (at < 0 || rank(map_keys[i]) < rank(map_keys[at])) at = i;
      if (at < 0) a.status = ST_NOT_FOUND;
      else begin
        a.status = ST_OK;
        a.key_out = map_keys[at];
        a.value_out = map_vals[at];
      end
    end else if (o <= OP_REMOVE && k != 0) begin
      case (o)
        OP_GET: begin
          at = find_key(k);
          if (at < 0) a.status = ST_NOT_FOUND;
          else begin
            a.status = ST_OK;
            a.value_out = map_vals[at];
          end
        end
        OP_FLOOR: begin
          for (int i = 0; i < map_count; i++)
            if (rank(map_keys[i]) <= rank(k) &&
                (at < 0 || rank(map_keys[i]) > rank(map_keys[at]))) at = i;
          if (at < 0) a.status = ST_NOT_FOUND;
          else begin
            a.status = ST_OK;
            a.key_out = map_keys[at];
            a.value_out = map_vals[at];
          end
        end
        OP_INSERT: begin
          at = find_key(k);
          if (at >= 0) begin
            a.status = ST_OK;
            a.value_out = map_vals[at];
            map_vals[at] = v;
          end else if (map_count >= CAPACITY) a.status = ST_FULL;
          else begin
            a.status = ST_OK;
            map_keys[map_count] = k;
            map_vals[map_count] = v;
            map_count++;
          end
        end
        default: begin
          at = find_key(k);
          if (at < 0) a.status = ST_NOT_FOUND;
          else begin
            a.status = ST_OK;
            a.value_out = map_vals[at];
            map_keys[at] = map_keys[map_count - 1];
            map_vals[at] = map_vals[map_count - 1];
            map_count--;
          end
        end
      endcase
    end
    a.count = COUNT_BITS'(map_count);
    return a;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: check on accept, then pick next stall at falling edge
  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && result_valid && !result_stall) begin
      got = '{status, key_out, value_out, entry_count_out};
      answers_seen <= answers_seen + 1;
      if (pending_answers.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status); errors++;
        end
        if (got.key_out !== want.key_out) begin
          $error("key_out: expected %h actual %h", want.key_out, got.key_out); errors++;
        end
        if (got.value_out !== want.value_out) begin
          $error("value_out: expected %h actual %h", want.value_out, got.value_out); errors++;
        end
        if (got.count !== want.count) begin
          $error("entry_count_out: expected %0d actual %0d", want.count, got.count); errors++;
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off) result_stall <= 1'b1;
      else if (quiet_out) result_stall <= 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        stall_left = gap_len();
        result_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  task automatic send_word(logic [2:0] o, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
    int g;
    g = quiet_in ? 0 : gap_len();
    if (g > 0) begin
      item_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    op <= o;
    key <= k;
    value <= v;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_answers.push_back(predict_answer(o, k, v));
    words_sent++;
    if (k != 0 && o == OP_INSERT) used_keys.push_back(k);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic set_order(logic s);
    drain();
    cfg_wdata <= s;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    signed_order = s;
  endtask

  function automatic logic [KEY_BITS-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && used_keys.size() != 0) return used_keys[$urandom_range(0, used_keys.size() - 1)];
    if (r < 7) return $urandom_range(0, 3) == 0 ? 32'h0 :
                      (r[0] ? 32'h8000_0000 : 32'hFFFF_FFFF);
    return {$urandom()};
  endfunction

  task automatic test_empty_and_null();
    send_word(OP_MIN, 32'h0, 32'h0);
    send_word(OP_GET, 32'h5, 32'h0);
    send_word(OP_FLOOR, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_REMOVE, 32'h5, 32'h0);
    send_word(OP_INSERT, 32'h0, 32'h1234);
    send_word(OP_GET, 32'h0, 32'h0);
    send_word(3'd5, 32'h7, 32'h0);
    send_word(3'd7, 32'h7, 32'h0);
  endtask

  task automatic test_extremes();
    send_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 32'h1, 32'h0);
    send_word(OP_INSERT, 32'h8000_0000, 32'hA5A5_5A5A);
    send_word(OP_INSERT, 32'h7FFF_FFFF, 32'h5A5A_A5A5);
    send_word(OP_INSERT, 32'h1, 32'hFFFF_FFFF);
    send_word(OP_MIN, 32'h0, 32'h0);
    send_word(OP_FLOOR, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_GET, 32'h8000_0000, 32'h0);
    set_order(1'b1);
    send_word(OP_MIN, 32'h0, 32'h0);
    send_word(OP_FLOOR, 32'hFFFF_FFFE, 32'h0);
    send_word(OP_FLOOR, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send_word(3'd6, 32'h1, 32'h0);
    set_order(1'b0);
  endtask

  task automatic test_fill_to_capacity();
    while (map_count < CAPACITY) send_word(OP_INSERT, {$urandom()} | 32'h1, {$urandom()});
    send_word(OP_INSERT, 32'h2, 32'h99);
    send_word(OP_INSERT, map_keys[0], 32'h77);
    send_word(OP_MIN, 32'h0, 32'h0);
    while (map_count > 4) send_word(OP_REMOVE, map_keys[$urandom_range(0, map_count - 1)], '0);
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    quiet_in = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      repeat (30) send_word(OP_GET, pick_key(), '0);
    join
    quiet_in = 1'b0;
  endtask

  task automatic test_random(int n);
    int r;
    logic [2:0] o;
    for (int i = 0; i < n; i++) begin
      if (i % 500 == 250) set_order($urandom_range(0, 1));
      quiet_out = ((i / 100) % 5 == 3);
      r = $urandom_range(0, 99);
      if (r < 35) o = OP_INSERT;
      else if (r < 55) o = OP_GET;
      else if (r < 70) o = OP_FLOOR;
      else if (r < 78) o = OP_MIN;
      else if (r < 97) o = OP_REMOVE;
      else o = 3'($urandom_range(5, 7));
      send_word(o, pick_key(), {$urandom()});
      if (used_keys.size() > 64) void'(used_keys.pop_front());
    end
    quiet_out = 1'b0;
  endtask

  initial begin
    cycles = 0;
    errors = 0;
    answers_seen = 0;
    words_sent = 0;
    map_count = 0;
    signed_order = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_order(1'b0);
    test_empty_and_null();
    test_extremes();
    test_backpressure();
    test_fill_to_capacity();
    test_random(1000);
    drain();
    $display("Sent %0d words, checked %0d results, both key orders, full store and long stall.",
             words_sent, answers_seen);
    if (errors == 0 && pending_answers.size() == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/okvm_pkg.sv
hw/rtl/okvm_ram.sv
hw/rtl/ordered_key_value_map.sv
dv/ordered_key_value_map_tb.sv
